// File: src/fmow_pkg.sv
`default_nettype none

package fmow_pkg;

	// Table size; the phase port is sized from it
	localparam int WAVE_POINTS = 1024;
	localparam int PHASE_W     = $clog2(WAVE_POINTS);
	localparam int QTR         = WAVE_POINTS / 4;
	localparam int QTR_W       = PHASE_W - 2;

	// Angles inside the ROM builder run at 1/(8*WAVE_POINTS) of a cycle
	localparam longint unsigned QUARTER_A   = 2 * WAVE_POINTS;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1 << 30;

	localparam int MAG_W    = 15;
	localparam int SAMPLE_W = 16;

	typedef logic [2:0]          shape_t;
	typedef logic [PHASE_W-1:0]  phase_t;
	typedef logic [QTR_W-1:0]    rom_idx_t;
	typedef logic [MAG_W-1:0]    mag_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam shape_t SHP_SINE          = 3'd0;
	localparam shape_t SHP_OFFSET        = 3'd1;
	localparam shape_t SHP_HALF          = 3'd2;
	localparam shape_t SHP_HALF_OFFSET   = 3'd3;
	localparam shape_t SHP_DOUBLE        = 3'd4;
	localparam shape_t SHP_DOUBLE_OFFSET = 3'd5;
	localparam shape_t SHP_DOUBLE_ABS    = 3'd6;
	localparam shape_t SHP_DOUBLE_FLIP   = 3'd7;

	typedef enum logic [1:0] {
		OFF_NONE,
		OFF_POS,
		OFF_NEG
	} offset_t;

	localparam mag_t   MAG_ONE = mag_t'(1 << 14);
	localparam phase_t QTR_PH  = phase_t'(QTR);

	typedef mag_t sine_rom_t [QTR];
	typedef longint unsigned sine_div_t [6];

	localparam sine_div_t SINE_DIVS = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	// First-quadrant sine, one entry per phase step, rounded to Q1.14
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t       rom;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned m;
		for (int k = 0; k < QTR; k++) begin
			r  = longint'(k) * 8;
			x  = (r * HALF_PI_Q30) / QUARTER_A;
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			for (int i = 0; i < 6; i++) begin
				t = ONE_Q30 - ((x2 * t) >> 30) / SINE_DIVS[i];
			end
			s = (x * t) >> 30;
			m = (s * 64'd16384 + (64'd1 << 29)) >> 30;
			if (m > 64'd16384) begin
				m = 64'd16384;
			end
			rom[k] = mag_t'(m);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// File: src/fmow_op_if.sv
`default_nettype none

interface fmow_op_if;
	logic            valid;
	logic            ready;
	fmow_pkg::shape_t shape;
	fmow_pkg::phase_t phase;

	modport source (output valid, output shape, output phase, input ready);
	modport sink   (input valid, input shape, input phase, output ready);
endinterface

`default_nettype wire

// File: src/fmow_smp_if.sv
`default_nettype none

interface fmow_smp_if;
	logic              valid;
	logic              ready;
	fmow_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// File: src/fm_operator_waveshape.sv
// Waveshape generator for an FM operator: eight sine variants in signed Q1.14.
//
// op  (sink):   a request carries shape (0..7) and phase (0..1023, a fraction of
//               one cycle). A request is taken on a clock edge with valid and
//               ready both high.
// smp (source): one sample per request, in request order, held until ready.
//
// A request passes through the stage registers one, two and three in order, and
// smp.valid rises when it reaches stage three. One request per cycle while smp
// is not stalled. Stage one decodes the shape into a ROM angle, sign and offset;
// stage two reads the 256-entry quarter-wave ROM; stage three applies sign,
// offset and the zero half-cycle.
//
// Reset clears the valid bits of all three stages; the pipeline is empty after.
// When smp is stalled the stages fill up behind it, and op.ready drops only
// when all three hold a sample. Nothing is dropped or repeated on a stall.
`default_nettype none

module fm_operator_waveshape (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fmow_op_if.sink     op,
	fmow_smp_if.source  smp
);
	import fmow_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic ld1, ld2, ld3;

	// stage 1 payload
	phase_t  u_s1;
	logic    neg_s1;
	offset_t off_s1;
	logic    zero_s1;

	// stage 2 payload
	mag_t    mag_s2;
	logic    neg_s2;
	offset_t off_s2;
	logic    zero_s2;

	// stage 3 payload
	sample_t sample_s3;

	// decode
	logic [2:0] oct;
	phase_t     p2;
	phase_t     u_d;
	logic       neg_d;
	offset_t    off_d;
	logic       zero_d;

	// ROM read
	logic [1:0]     quad;
	rom_idx_t       r_low;
	logic [QTR_W:0] idx;
	mag_t           mag_d;

	// output arithmetic
	logic signed [SAMPLE_W:0] term;
	logic signed [SAMPLE_W:0] sum;

	assign ld3      = !v_s3 || smp.ready;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign op.ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= op.valid;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage 1: pick the ROM angle and what to do with its value
	always_comb begin
		oct    = op.phase[PHASE_W-1 -: 3];
		p2     = {op.phase[PHASE_W-2:0], 1'b0};
		u_d    = op.phase;
		neg_d  = 1'b0;
		off_d  = OFF_NONE;
		zero_d = 1'b0;
		unique case (op.shape) inside
			SHP_SINE: begin
				u_d = op.phase;
			end
			SHP_OFFSET, SHP_HALF_OFFSET: begin
				u_d    = oct[1] ? op.phase + QTR_PH : op.phase - QTR_PH;
				off_d  = oct[2] ? OFF_NEG : OFF_POS;
				zero_d = (op.shape == SHP_HALF_OFFSET) && oct[2];
			end
			SHP_HALF: begin
				zero_d = oct[2];
			end
			SHP_DOUBLE: begin
				u_d    = p2;
				zero_d = oct[2];
			end
			SHP_DOUBLE_OFFSET: begin
				u_d    = oct[0] ? p2 + QTR_PH : p2 - QTR_PH;
				off_d  = oct[1] ? OFF_NEG : OFF_POS;
				zero_d = oct[2];
			end
			SHP_DOUBLE_ABS: begin
				u_d    = p2;
				neg_d  = oct[1];
				zero_d = oct[2];
			end
			SHP_DOUBLE_FLIP: begin
				u_d    = oct[0] ? p2 + QTR_PH : p2 - QTR_PH;
				neg_d  = oct[1];
				off_d  = OFF_POS;
				zero_d = oct[2];
			end
			default: begin
				zero_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			u_s1    <= u_d;
			neg_s1  <= neg_d;
			off_s1  <= off_d;
			zero_s1 <= zero_d;
		end
	end

	// Stage 2: fold the angle into the first quadrant and read the ROM
	always_comb begin
		quad  = u_s1[PHASE_W-1 -: 2];
		r_low = u_s1[QTR_W-1:0];
		idx   = quad[0] ? (QTR_W+1)'(QTR) - {1'b0, r_low} : {1'b0, r_low};
		mag_d = idx[QTR_W] ? MAG_ONE : SINE_ROM[idx[QTR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			mag_s2  <= mag_d;
			neg_s2  <= neg_s1 ^ quad[1];
			off_s2  <= off_s1;
			zero_s2 <= zero_s1;
		end
	end

	// Stage 3: sign, offset and the silent half
	always_comb begin
		term = neg_s2 ? -$signed({2'b00, mag_s2}) : $signed({2'b00, mag_s2});
		case (off_s2)
			OFF_POS: sum = term + $signed((SAMPLE_W+1)'(1 << 14));
			OFF_NEG: sum = term - $signed((SAMPLE_W+1)'(1 << 14));
			default: sum = term;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			sample_s3 <= zero_s2 ? '0 : sample_t'(sum[SAMPLE_W-1:0]);
		end
	end

	assign smp.valid  = v_s3;
	assign smp.sample = sample_s3;

	// hold stage one while stage two cannot take it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !ld2 |=> v_s1 && $stable(u_s1) && $stable(off_s1))
		else $error("stage one payload lost on stall");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> mag_s2 <= MAG_ONE)
		else $error("ROM magnitude beyond one");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		smp.valid |-> ($signed(smp.sample) <= 16384 && $signed(smp.sample) >= -16384))
		else $error("sample outside Q1.14 range");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!smp.valid |-> op.ready)
		else $error("request refused with output stage empty");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fmow_pkg::*;

	localparam int unsigned     PTS         = WAVE_POINTS;
	localparam int unsigned     FULL_ANG    = 8 * PTS;
	localparam int unsigned     QTR_ANG     = 2 * PTS;
	localparam longint unsigned PI_2_Q30    = 64'd1686629713;
	localparam longint unsigned Q30_ONE     = 64'd1 << 30;
	localparam int              FULL_SCALE  = 16384;
	localparam int              CYCLE_LIMIT = 200000;
	localparam int              RANDOM_REQS = 500;

	typedef struct {
		bit     hold;
		shape_t shape;
		phase_t phase;
	} wave_req_t;

	logic clk;
	logic arst_n;

	fmow_op_if  op_ch();
	fmow_smp_if smp_ch();

	fm_operator_waveshape i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_ch.sink),
		.smp    (smp_ch.source)
	);

	wave_req_t pending_reqs[$];
	sample_t   expected_samples[$];
	int        src_idle_pct;
	int        snk_idle_pct;
	int        mismatches;
	int        cycle_count;

	function automatic longint unsigned taylor_div(int i);
		case (i)
			0: return 64'd156;
			1: return 64'd110;
			2: return 64'd72;
			3: return 64'd42;
			4: return 64'd20;
			default: return 64'd6;
		endcase
	endfunction

	// Angle is in units of 1/(8*PTS) of a cycle
	function automatic int sine_q14_at(int unsigned angle);
		int unsigned     a;
		int unsigned     quad;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned mag;
		a    = angle % FULL_ANG;
		quad = a / QTR_ANG;
		r    = a % QTR_ANG;
		if (quad[0]) begin
			r = QTR_ANG - r;
		end
		x  = (r * PI_2_Q30) / QTR_ANG;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		for (int i = 0; i < 6; i++) begin
			t = Q30_ONE - ((x2 * t) >> 30) / taylor_div(i);
		end
		s   = (x * t) >> 30;
		mag = (s * 64'd16384 + (64'd1 << 29)) >> 30;
		if (mag > 64'd16384) begin
			mag = 64'd16384;
		end
		return (quad >= 2) ? -int'(mag) : int'(mag);
	endfunction

	function automatic sample_t waveshape_sample(shape_t sh, phase_t ph);
		int unsigned p;
		int unsigned a1;
		int unsigned a2;
		bit          first_half;
		int          v;
		p          = ph % PTS;
		a1         = 8 * p;
		a2         = 16 * p;
		first_half = (2 * p < PTS);
		v          = 0;
		case (sh) inside
			SHP_SINE: v = sine_q14_at(a1);
			SHP_OFFSET, SHP_HALF_OFFSET: begin
				if (4 * p < PTS)
					v = sine_q14_at(a1 + FULL_ANG - QTR_ANG) + FULL_SCALE;
				else if (first_half)
					v = sine_q14_at(a1 + QTR_ANG) + FULL_SCALE;
				else if (sh == SHP_HALF_OFFSET)
					v = 0;
				else if (4 * p < 3 * PTS)
					v = sine_q14_at(a1 + FULL_ANG - QTR_ANG) - FULL_SCALE;
				else
					v = sine_q14_at(a1 + QTR_ANG) - FULL_SCALE;
			end
			SHP_HALF: v = first_half ? sine_q14_at(a1) : 0;
			SHP_DOUBLE: v = first_half ? sine_q14_at(a2) : 0;
			SHP_DOUBLE_OFFSET: begin
				if (8 * p < PTS)
					v = sine_q14_at(a2 + FULL_ANG - QTR_ANG) + FULL_SCALE;
				else if (4 * p < PTS)
					v = sine_q14_at(a2 + QTR_ANG) + FULL_SCALE;
				else if (8 * p < 3 * PTS)
					v = sine_q14_at(a2 + FULL_ANG - QTR_ANG) - FULL_SCALE;
				else if (first_half)
					v = sine_q14_at(a2 + QTR_ANG) - FULL_SCALE;
			end
			SHP_DOUBLE_ABS: begin
				if (4 * p < PTS)
					v = sine_q14_at(a2);
				else if (first_half)
					v = -sine_q14_at(a2);
			end
			SHP_DOUBLE_FLIP: begin
				if (8 * p < PTS)
					v = FULL_SCALE + sine_q14_at(a2 + FULL_ANG - QTR_ANG);
				else if (4 * p < PTS)
					v = FULL_SCALE + sine_q14_at(a2 + QTR_ANG);
				else if (8 * p < 3 * PTS)
					v = FULL_SCALE - sine_q14_at(a2 + FULL_ANG - QTR_ANG);
				else if (first_half)
					v = FULL_SCALE - sine_q14_at(a2 + QTR_ANG);
			end
			default: v = 0;
		endcase
		return sample_t'(v);
	endfunction

	function automatic wave_req_t make_req(int sh, int ph);
		wave_req_t req;
		req.hold  = 1'b0;
		req.shape = shape_t'(sh);
		req.phase = phase_t'(ph);
		return req;
	endfunction

	// About half the phases land on or next to a multiple of PTS/8
	task automatic queue_random(int n);
		wave_req_t req;
		int        ph;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) begin
				req      = make_req(0, 0);
				req.hold = 1'b1;
				pending_reqs.push_back(req);
			end
			if ($urandom_range(1) == 0)
				ph = $urandom_range(7) * (PTS / 8) + $urandom_range(2) - 1;
			else
				ph = $urandom_range(PTS - 1);
			pending_reqs.push_back(make_req($urandom_range(7), ph & (PTS - 1)));
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || op_ch.valid || expected_samples.size() != 0)
			@(negedge clk);
	endtask

	always #4 clk = ~clk;

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		bit        launch;
		wave_req_t req;
		if (!arst_n) begin
			op_ch.valid <= 1'b0;
			op_ch.shape <= '0;
			op_ch.phase <= '0;
		end else begin
			launch = 1'b0;
			if (op_ch.valid && op_ch.ready)
				expected_samples.push_back(waveshape_sample(op_ch.shape, op_ch.phase));
			if (!op_ch.valid || op_ch.ready) begin
				if (pending_reqs.size() != 0) begin
					if (pending_reqs[0].hold) begin
						// hold until every outstanding sample has come back
						if (expected_samples.size() == 0)
							void'(pending_reqs.pop_front());
					end else if ($urandom_range(99) >= src_idle_pct) begin
						req    = pending_reqs.pop_front();
						launch = 1'b1;
						op_ch.shape <= req.shape;
						op_ch.phase <= req.phase;
					end
				end
				op_ch.valid <= launch;
			end
		end
	end

	// Sample monitor
	always @(posedge clk or negedge arst_n) begin
		sample_t want;
		if (!arst_n) begin
			smp_ch.ready <= 1'b0;
		end else begin
			if (smp_ch.valid && smp_ch.ready) begin
				if (expected_samples.size() == 0) begin
					$error("unexpected sample %0d", smp_ch.sample);
					mismatches++;
				end else begin
					want = expected_samples.pop_front();
					if (smp_ch.sample !== want) begin
						$error("sample mismatch: expected %0d, got %0d", want, smp_ch.sample);
						mismatches++;
					end
				end
			end
			smp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL fm_operator_waveshape");
			$finish;
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		op_ch.valid  = 1'b0;
		op_ch.shape  = '0;
		op_ch.phase  = '0;
		smp_ch.ready = 1'b0;
		mismatches   = 0;
		cycle_count  = 0;
		src_idle_pct = 38;
		snk_idle_pct = 58;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every shape at both phase extremes, then the region boundaries
		for (int sh = 0; sh < 8; sh++) begin
			pending_reqs.push_back(make_req(sh, 0));
			pending_reqs.push_back(make_req(sh, PTS - 1));
		end
		pending_reqs.push_back(make_req(SHP_DOUBLE_OFFSET, PTS / 8 - 1));
		pending_reqs.push_back(make_req(SHP_DOUBLE_OFFSET, PTS / 8));
		pending_reqs.push_back(make_req(SHP_DOUBLE_FLIP, PTS / 4 - 1));
		pending_reqs.push_back(make_req(SHP_DOUBLE_FLIP, PTS / 4));
		pending_reqs.push_back(make_req(SHP_OFFSET, 3 * PTS / 8));
		pending_reqs.push_back(make_req(SHP_DOUBLE_ABS, PTS / 2 - 1));
		pending_reqs.push_back(make_req(SHP_HALF_OFFSET, PTS / 2));
		pending_reqs.push_back(make_req(SHP_HALF, 3 * PTS / 4));
		pending_reqs.push_back(make_req(SHP_DOUBLE, PTS / 4));
		queue_random(RANDOM_REQS);
		wait_drained();

		src_idle_pct = 58;
		snk_idle_pct = 38;
		queue_random(RANDOM_REQS);
		wait_drained();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		queue_random(RANDOM_REQS);
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("PASS fm_operator_waveshape");
		else
			$display("FAIL fm_operator_waveshape");
		$finish;
	end

endmodule

`default_nettype wire
